/* hdl/srs_pkg.sv */
// Shared constants, codes and types for the substring replace stream.
`timescale 1ns / 1ps
package srs_pkg;

  // Per-text output capacity in bytes
  localparam int unsigned MaxOut   = 2047;
  localparam int unsigned CntW     = $clog2(MaxOut + 1);
  // Longest find pattern and replacement, in bytes
  localparam int unsigned MaxPat   = 8;
  localparam int unsigned LenW     = 4;
  // Results one input byte may produce
  localparam int unsigned ResMax   = 8;
  localparam int unsigned SlotCntW = $clog2(ResMax + 1);
  localparam int unsigned SlotIdxW = $clog2(ResMax);
  // Working buffer: window plus new byte, padded so shifted reads stay in range
  localparam int unsigned BufN     = 2 * MaxPat;
  localparam int unsigned BufIdxW  = $clog2(BufN);
  // Job queue between front and back
  localparam int unsigned QDepth   = 2;
  localparam int unsigned QPtrW    = $clog2(QDepth);

  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 64;

  typedef enum logic [CfgIdxW-1:0] {
    RegFindPattern   = 2'd0,
    RegFindLength    = 2'd1,
    RegReplaceText   = 2'd2,
    RegReplaceLength = 2'd3
  } srs_reg_e;

  // Results produced by one accepted byte
  typedef struct packed {
    logic [ResMax-1:0][7:0] data;
    logic [SlotCntW-1:0]    cnt;     // results in this job, 1 .. ResMax
    logic                   last;    // job closes the text
    logic                   trunc;   // truncated flag for every result
    logic                   marker;  // single end marker, no byte carried
  } srs_job_t;

endpackage

/* hdl/srs_front.sv */
// Front end: configuration registers, lookahead window and match classification.
`timescale 1ns / 1ps
module srs_front import srs_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  // configuration writes
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  // text bytes
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [7:0]          in_byte_i,
  input  logic                in_last_i,
  // jobs towards the queue
  output logic                push_o,
  output srs_job_t            job_o,
  input  logic                full_i
);

  logic [MaxPat-1:0][7:0] pat_q, rep_q;
  logic [LenW-1:0]        flen_raw_q, rlen_raw_q;

  logic [MaxPat-1:0][7:0] win_q, win_d;
  logic [LenW-1:0]        cnt_q, cnt_d;
  logic [CntW-1:0]        emit_q, emit_d;
  logic                   ovf_q, ovf_d;

  logic [BufN-1:0][7:0]   buf_w;
  logic [LenW-1:0]        n_w, flen, rlen, start_w, pre_w;
  logic                   hit_w, fits_w, accept;
  logic [4:0]             tail_w, req_w, lim_w, sends_w;
  logic [CntW-1:0]        avail_w;
  logic [BufIdxW-1:0]     bidx;

  assign in_ready_o = !full_i;
  assign accept     = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pat_q      <= '0;
      rep_q      <= '0;
      flen_raw_q <= '0;
      rlen_raw_q <= '0;
    end else if (cfg_we_i) begin
      unique case (srs_reg_e'(cfg_index_i))
        RegFindPattern:   pat_q      <= cfg_data_i;
        RegFindLength:    flen_raw_q <= cfg_data_i[LenW-1:0];
        RegReplaceText:   rep_q      <= cfg_data_i;
        RegReplaceLength: rlen_raw_q <= cfg_data_i[LenW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    flen = (flen_raw_q > LenW'(MaxPat)) ? LenW'(MaxPat) : flen_raw_q;
    rlen = (rlen_raw_q > LenW'(MaxPat)) ? LenW'(MaxPat) : rlen_raw_q;
    n_w  = cnt_q + LenW'(1);

    // window bytes, then the new byte, then zeros
    for (int i = 0; i < BufN; i++) begin
      if (i < MaxPat && LenW'(i) < cnt_q) begin
        buf_w[i] = win_q[i % MaxPat];
      end else if (i <= MaxPat && LenW'(i) == cnt_q) begin
        buf_w[i] = in_byte_i;
      end else begin
        buf_w[i] = '0;
      end
    end

    fits_w = (n_w >= flen);
    hit_w  = (flen != '0) && fits_w;
    for (int i = 0; i < MaxPat; i++) begin
      if (LenW'(i) < flen && buf_w[i] != pat_q[i]) begin
        hit_w = 1'b0;
      end
    end

    priority if (hit_w) begin
      pre_w   = rlen;
      start_w = flen;
    end else if (fits_w) begin
      pre_w   = LenW'(1);
      start_w = LenW'(1);
    end else begin
      pre_w   = '0;
      start_w = '0;
    end

    tail_w  = in_last_i ? 5'(n_w - start_w) : 5'd0;
    req_w   = 5'(pre_w) + tail_w;
    avail_w = CntW'(MaxOut) - emit_q;
    lim_w   = (avail_w < CntW'(ResMax)) ? 5'(avail_w) : 5'(ResMax);
    sends_w = (req_w < lim_w) ? req_w : lim_w;

    // prefix from the replacement or the oldest byte, then the flushed tail
    job_o.data = '0;
    for (int j = 0; j < ResMax; j++) begin
      bidx = BufIdxW'(start_w) + BufIdxW'(j) - BufIdxW'(pre_w);
      if (LenW'(j) < pre_w) begin
        job_o.data[j] = hit_w ? rep_q[j % MaxPat] : buf_w[0];
      end else begin
        job_o.data[j] = buf_w[bidx];
      end
    end
    job_o.marker = (sends_w == '0);
    job_o.cnt    = job_o.marker ? SlotCntW'(1) : SlotCntW'(sends_w);
    job_o.last   = in_last_i;
    job_o.trunc  = ovf_q || (sends_w != req_w);

    for (int i = 0; i < MaxPat; i++) begin
      bidx     = BufIdxW'(start_w) + BufIdxW'(i);
      win_d[i] = buf_w[bidx];
    end
    cnt_d  = n_w - start_w;
    emit_d = emit_q + CntW'(sends_w);
    ovf_d  = job_o.trunc;
  end

  assign push_o = accept && (!job_o.marker || in_last_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_q  <= '0;
      cnt_q  <= '0;
      emit_q <= '0;
      ovf_q  <= 1'b0;
    end else if (accept) begin
      if (in_last_i) begin
        // start the next text from a clean window
        win_q  <= '0;
        cnt_q  <= '0;
        emit_q <= '0;
        ovf_q  <= 1'b0;
      end else begin
        win_q  <= win_d;
        cnt_q  <= cnt_d;
        emit_q <= emit_d;
        ovf_q  <= ovf_d;
      end
    end
  end

endmodule

/* hdl/srs_queue.sv */
// Two-entry job queue between the front end and the output serialiser.
`timescale 1ns / 1ps
module srs_queue import srs_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     push_i,
  input  srs_job_t job_i,
  output logic     full_o,
  input  logic     pop_i,
  output srs_job_t job_o,
  output logic     empty_o
);

  srs_job_t [QDepth-1:0] mem_q;
  logic [QPtrW-1:0]      wr_q, rd_q;
  logic [QPtrW:0]        cnt_q;

  assign full_o  = (cnt_q == (QPtrW+1)'(QDepth));
  assign empty_o = (cnt_q == '0);
  assign job_o   = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= job_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= wr_q + QPtrW'(1);
      end
      if (pop_i) begin
        rd_q <= rd_q + QPtrW'(1);
      end
      cnt_q <= cnt_q + (QPtrW+1)'(push_i) - (QPtrW+1)'(pop_i);
    end
  end

endmodule

/* hdl/srs_back.sv */
// Back end: walks each job one result per cycle, when not stalled, into the output register.
`timescale 1ns / 1ps
module srs_back import srs_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  srs_job_t   job_i,
  input  logic       empty_i,
  output logic       pop_o,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [7:0] out_byte_o,
  output logic       out_present_o,
  output logic       out_last_o,
  output logic       out_trunc_o
);

  logic [SlotIdxW-1:0] idx_q;
  logic                valid_q, load, take, final_slot;

  assign load       = !valid_q || out_ready_i;
  assign take       = load && !empty_i;
  assign final_slot = (SlotCntW'(idx_q) == job_i.cnt - SlotCntW'(1));
  assign pop_o      = take && final_slot;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      idx_q   <= '0;
    end else begin
      if (load) begin
        valid_q <= !empty_i;
      end
      if (take) begin
        idx_q <= final_slot ? '0 : idx_q + SlotIdxW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      out_byte_o    <= job_i.marker ? 8'd0 : job_i.data[idx_q];
      out_present_o <= !job_i.marker;
      out_last_o    <= job_i.last && final_slot;
      out_trunc_o   <= job_i.trunc;
    end
  end

  assign out_valid_o = valid_q;

endmodule

/* hdl/substring_replace_stream.sv */
// Top level of the streaming find-and-replace block.
// A result passes through the job queue and the output register. Throughput: one byte
// per cycle while each byte yields at most one result and the output is not stalled;
// a byte that yields several results holds the output serialiser until all are sent,
// and the two-entry job queue then stalls input. Reset (async, active low) clears
// configuration registers to zero, empties the window, queue and output register.
`timescale 1ns / 1ps
module substring_replace_stream import srs_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  // configuration write channel
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  // text in
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  input  logic [7:0]          s_axis_tdata,   // [7:0] text_byte
  input  logic                s_axis_tlast,   // text_last
  // results out
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  output logic [7:0]          m_axis_tdata,   // [7:0] result_byte
  output logic [1:0]          m_axis_tuser,   // [0] byte_present, [1] was_truncated
  output logic                m_axis_tlast    // result_last
);

  srs_job_t push_job, head_job;
  logic     push, full, pop, empty;

  assign cfg_ready_o = 1'b1;

  srs_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_valid_i && cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .in_byte_i   (s_axis_tdata),
    .in_last_i   (s_axis_tlast),
    .push_o      (push),
    .job_o       (push_job),
    .full_i      (full)
  );

  srs_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .job_i   (push_job),
    .full_o  (full),
    .pop_i   (pop),
    .job_o   (head_job),
    .empty_o (empty)
  );

  srs_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .job_i         (head_job),
    .empty_i       (empty),
    .pop_o         (pop),
    .out_valid_o   (m_axis_tvalid),
    .out_ready_i   (m_axis_tready),
    .out_byte_o    (m_axis_tdata),
    .out_present_o (m_axis_tuser[0]),
    .out_last_o    (m_axis_tlast),
    .out_trunc_o   (m_axis_tuser[1])
  );

endmodule

/* hdl/srs_checker.sv */
// Port-level checker for the substring replace stream, bound to the top level.
`timescale 1ns / 1ps
module srs_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       s_axis_tready,
  input logic       m_axis_tvalid,
  input logic       m_axis_tready,
  input logic [7:0] m_axis_tdata,
  input logic [1:0] m_axis_tuser,
  input logic       m_axis_tlast
);

  // hold a stalled result transaction
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)
      && $stable(m_axis_tlast))
    else $error("result changed while stalled");

  // an end marker always closes the text
  a_marker_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tuser[0] |-> m_axis_tlast)
    else $error("end marker without tlast");

  // an end marker carries no byte
  a_marker_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tuser[0] |-> m_axis_tdata == 8'd0)
    else $error("end marker with data");

  // input back-pressure only comes from a backlog at the output
  a_stall_backlog: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> m_axis_tvalid)
    else $error("input stalled with empty output");

endmodule

bind substring_replace_stream srs_checker u_srs_checker (.*);

/* tb/sv/tb_top.sv */
// Self-checking testbench for the streaming find-and-replace block.
`timescale 1ns / 1ps
module tb_top;
  import srs_pkg::*;

  localparam int unsigned SettleCycles = 12;
  localparam int unsigned CycleLimit   = 400000;
  localparam logic [7:0]  HitChar      = 8'h61;

  typedef logic [7:0] char_q_t [$];

  typedef struct packed {
    logic [7:0] ch;
    logic       present;
    logic       fin;
    logic       trunc;
  } text_result_t;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                cfg_valid_i = 1'b0;
  logic                cfg_ready_o;
  logic [CfgIdxW-1:0]  cfg_index_i = '0;
  logic [CfgDataW-1:0] cfg_data_i = '0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [7:0]          s_axis_tdata = '0;   // [7:0] text_byte
  logic                s_axis_tlast = 1'b0; // text_last
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [7:0]          m_axis_tdata;        // [7:0] result_byte
  logic [1:0]          m_axis_tuser;        // [0] byte_present, [1] was_truncated
  logic                m_axis_tlast;        // result_last

  substring_replace_stream dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  initial begin : clock_gen
    forever #2 clk_i = ~clk_i;
  end

  // Shadow copy of the configuration and the per-text state
  logic [63:0]  pat_reg = '0;
  logic [3:0]   pat_len_reg = '0;
  logic [63:0]  rep_reg = '0;
  logic [3:0]   rep_len_reg = '0;
  logic [7:0]   look_bytes [MaxPat];
  int unsigned  look_cnt = 0;
  int unsigned  sent_cnt = 0;
  logic         overflow_flag = 1'b0;
  logic [7:0]   step_chars [$];

  text_result_t awaited_output [$];
  int unsigned  error_count = 0;
  int unsigned  items_sent = 0;
  int unsigned  hold_off_req = 0;
  bit           idle_on = 1'b1;

  function automatic int unsigned clamp_len(input logic [3:0] v);
    return (v > MaxPat) ? MaxPat : int'(v);
  endfunction

  // Drop the byte once the step or the text has no room left
  function automatic void emit_char(input logic [7:0] ch);
    if (step_chars.size() >= ResMax || sent_cnt >= MaxOut) begin
      overflow_flag = 1'b1;
    end else begin
      step_chars.push_back(ch);
      sent_cnt++;
    end
  endfunction

  function automatic void predict_replace(input logic [7:0] ch, input logic fin);
    logic [7:0]  scan [MaxPat+1];
    int unsigned n, flen, rlen, start, i;
    bit          hit;
    step_chars.delete();
    n = look_cnt;
    for (i = 0; i < n; i++) scan[i] = look_bytes[i];
    scan[n] = ch;
    n++;
    flen = clamp_len(pat_len_reg);
    rlen = clamp_len(rep_len_reg);
    hit = 1'b0;
    start = 0;
    if (flen > 0 && n >= flen) begin
      hit = 1'b1;
      for (i = 0; i < flen; i++)
        if (scan[i] != pat_reg[8*i +: 8]) hit = 1'b0;
    end
    if (hit) begin
      for (i = 0; i < rlen; i++) emit_char(rep_reg[8*i +: 8]);
      start = flen;
    end else if (n >= flen) begin
      emit_char(scan[0]);
      start = 1;
    end
    // Flush the rest of the window without matching
    if (fin) begin
      for (i = start; i < n; i++) emit_char(scan[i]);
      start = n;
    end
    look_cnt = n - start;
    for (i = 0; i < look_cnt; i++) look_bytes[i] = scan[start + i];
    if (fin && step_chars.size() == 0) begin
      awaited_output.push_back('{ch: 8'h00, present: 1'b0, fin: 1'b1, trunc: overflow_flag});
    end else begin
      foreach (step_chars[j])
        awaited_output.push_back('{ch: step_chars[j], present: 1'b1,
                                   fin: fin && (j == step_chars.size() - 1),
                                   trunc: overflow_flag});
    end
    if (fin) begin
      look_cnt = 0;
      sent_cnt = 0;
      overflow_flag = 1'b0;
    end
  endfunction

  function automatic void compare_field(input string name, input int unsigned want,
                                        input int unsigned got);
    if (want != got) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      error_count++;
    end
  endfunction

  function automatic void check_result();
    text_result_t want;
    if (awaited_output.size() == 0) begin
      $error("unexpected result: result_byte 0x%0h, tuser 0x%0h, tlast %0b",
             m_axis_tdata, m_axis_tuser, m_axis_tlast);
      error_count++;
    end else begin
      want = awaited_output.pop_front();
      compare_field("result_byte", want.ch, m_axis_tdata);
      compare_field("byte_present", want.present, m_axis_tuser[0]);
      compare_field("result_last", want.fin, m_axis_tlast);
      compare_field("was_truncated", want.trunc, m_axis_tuser[1]);
    end
  endfunction

  initial begin : result_sink
    int unsigned stall_left = 0;
    int unsigned hold_left = 0;
    forever begin
      @(posedge clk_i);
      if (m_axis_tvalid && m_axis_tready) check_result();
      if (hold_off_req != 0) begin
        hold_left = hold_off_req;
        hold_off_req = 0;
      end
      if (hold_left != 0) hold_left--;
      else if (stall_left != 0) stall_left--;
      else if (idle_on && $urandom_range(0, 5) == 0) stall_left = $urandom_range(1, 14);
      m_axis_tready <= (hold_left == 0) && (stall_left == 0);
    end
  end

  initial begin : watchdog
    int unsigned cycle_count = 0;
    while (cycle_count < CycleLimit) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("DONE: errors detected");
    $finish;
  end

  function automatic int unsigned idle_gap();
    if (idle_on && $urandom_range(0, 3) == 0) return $urandom_range(1, 14);
    return 0;
  endfunction

  task automatic send_char(input logic [7:0] ch, input logic fin);
    int unsigned gap;
    gap = idle_gap();
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= ch;
    s_axis_tlast  <= fin;
    do @(posedge clk_i); while (!s_axis_tready);
    predict_replace(ch, fin);
    items_sent++;
  endtask

  task automatic send_text(input char_q_t text, input logic closes);
    foreach (text[i]) send_char(text[i], closes && (i == text.size() - 1));
  endtask

  // Wait for every awaited result, then for any byte still inside the pipeline
  task automatic settle();
    s_axis_tvalid <= 1'b0;
    while (awaited_output.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic write_reg(input srs_reg_e idx, input logic [63:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      RegFindPattern:   pat_reg = val;
      RegFindLength:    pat_len_reg = val[3:0];
      RegReplaceText:   rep_reg = val;
      RegReplaceLength: rep_len_reg = val[3:0];
      default: ;
    endcase
  endtask

  task automatic configure(input logic [63:0] pat, input logic [3:0] flen,
                           input logic [63:0] rep, input logic [3:0] rlen);
    settle();
    write_reg(RegFindPattern, pat);
    write_reg(RegFindLength, {60'd0, flen});
    write_reg(RegReplaceText, rep);
    write_reg(RegReplaceLength, {60'd0, rlen});
    cfg_valid_i <= 1'b0;
  endtask

  task automatic random_config();
    logic [63:0] pat;
    int unsigned i;
    // Small alphabet so that matches and near matches are common
    for (i = 0; i < MaxPat; i++)
      pat[8*i +: 8] = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(1, 255))
                                                   : 8'(HitChar + $urandom_range(0, 2));
    configure(pat, 4'($urandom_range(0, MaxPat)), {$urandom, $urandom},
              4'($urandom_range(0, MaxPat)));
  endtask

  function automatic char_q_t make_text(input int unsigned len);
    char_q_t     t;
    logic [7:0]  b;
    int unsigned flen, cut, i;
    flen = clamp_len(pat_len_reg);
    while (t.size() < len) begin
      case ($urandom_range(0, 3))
        0: t.push_back(8'($urandom_range(1, 255)));
        1, 2: begin
          // whole pattern or a prefix of it
          cut = (flen == 0) ? 1 : (($urandom_range(0, 1) == 0) ? flen : $urandom_range(1, flen));
          for (i = 0; i < cut; i++) begin
            b = pat_reg[8*i +: 8];
            t.push_back((b == 8'h00) ? 8'h01 : b);
          end
        end
        default: begin
          b = pat_reg[8*$urandom_range(0, MaxPat - 1) +: 8];
          t.push_back((b == 8'h00) ? 8'h01 : b);
        end
      endcase
    end
    while (t.size() > len) void'(t.pop_back());
    return t;
  endfunction

  function automatic char_q_t heavy_text(input int unsigned len);
    char_q_t t;
    repeat (len)
      t.push_back(($urandom_range(0, 15) == 0) ? 8'($urandom_range(1, 255)) : HitChar);
    return t;
  endfunction

  task automatic test_pass_through();
    configure(64'h0, 4'd0, 64'h0000_0000_0043_4241, 4'd3);
    send_text('{8'h01, 8'hFF}, 1'b1);
  endtask

  task automatic test_leftmost_match();
    configure(64'h6161, 4'd2, 64'h5A5958, 4'd3);
    send_text('{8'h61, 8'h61, 8'h61, 8'h62}, 1'b1);
  endtask

  // Empty replacement: a final byte that yields nothing sends the end marker
  task automatic test_deleted_match();
    configure(64'h71, 4'd1, 64'hFFFF_FFFF_FFFF_FFFF, 4'd0);
    send_text('{8'h71}, 1'b1);
    send_text('{8'h78, 8'h71}, 1'b1);
  endtask

  task automatic test_zero_pattern_byte();
    configure(64'h0061, 4'd2, 64'h7A7A, 4'd2);
    send_text('{8'h61, 8'h01}, 1'b1);
  endtask

  // Lengths above the pattern size act as the full eight bytes
  task automatic test_clamped_lengths();
    configure(64'h80FF_7F01_4020_1008, 4'hF, 64'hFEDC_BA98_7654_3210, 4'h9);
    send_text('{8'h08, 8'h10, 8'h20, 8'h40, 8'h01, 8'h7F, 8'hFF, 8'h80}, 1'b1);
  endtask

  // Shrink the pattern with a full window held, so one byte overruns a step
  task automatic test_mid_text_config();
    configure(64'h0102_0304_0506_0708, 4'd8, 64'h0, 4'd0);
    send_text('{8'h61, 8'h62, 8'h63, 8'h64, 8'h65, 8'h66, 8'h67}, 1'b0);
    configure(64'h61, 4'd1, 64'h0123_4567_89AB_CDEF, 4'd8);
    send_text('{8'h68}, 1'b1);
  endtask

  task automatic test_random_texts(input int unsigned count);
    char_q_t     text, head, tail;
    int unsigned goal, cut;
    goal = items_sent + count;
    while (items_sent < goal) begin
      if ($urandom_range(0, 1) == 0) random_config();
      text = make_text($urandom_range(1, 14));
      if (text.size() > 1 && $urandom_range(0, 4) == 0) begin
        cut  = $urandom_range(1, text.size() - 1);
        head = text[0:cut-1];
        tail = text[cut:$];
        send_text(head, 1'b0);
        random_config();
        send_text(tail, 1'b1);
      end else begin
        send_text(text, 1'b1);
      end
    end
  endtask

  // Eight bytes out per hit: the text runs past the output capacity
  task automatic test_capacity();
    configure(64'(HitChar), 4'd1, {$urandom, $urandom}, 4'd8);
    send_text(heavy_text(290), 1'b1);
  endtask

  task automatic test_backpressure();
    configure(64'(HitChar), 4'd1, {$urandom, $urandom}, 4'd8);
    hold_off_req = 300;
    send_text(heavy_text(20), 1'b1);
  endtask

  initial begin : test_sequence
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_pass_through();
    test_leftmost_match();
    test_deleted_match();
    test_zero_pattern_byte();
    test_clamped_lengths();
    test_mid_text_config();
    test_random_texts(20);
    test_capacity();
    test_backpressure();
    idle_on = 1'b0;
    test_random_texts(15);
    settle();
    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
